### sv/assert_macros.svh
// assertion macros for the rtl file gregorian_date_shift_and_diff
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gdsd_pkg.sv
// gdsd_pkg: field widths, calendar constants and small helper functions
// for the gregorian date shift and difference block; no dependencies
package gdsd_pkg;

  localparam int OFFSET_BITS_DEF = 17;
  localparam int YEAR_W          = 14;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int WDAY_W          = 3;
  localparam int DIFF_W          = 23;
  localparam int BY_W            = 15;  // biased year, year + 400
  localparam int SER_W           = 23;  // unsigned day serial

  localparam int YEAR_BIAS   = 400;
  localparam int DAYS_YEAR   = 365;
  localparam int CYCLE_DAYS  = 146097;
  localparam int DIFF_LIMIT  = 3660000;
  localparam int SER_LO      = 146463;   // 0001-01-01
  localparam int SER_HI      = 3798521;  // 9999-12-31
  localparam int WDAY_SER0   = 6;        // weekday of serial 0

  // days in month m, 1 = january
  function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(x / 100) by reciprocal, exact for x below 25600
  function automatic logic [7:0] div100(input logic [BY_W-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(5243);
    return p[26:19];
  endfunction

  // v mod 7 for v up to 40
  function automatic logic [WDAY_W-1:0] mod7(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 5; i++) begin
      if (t >= 6'd7) begin
        t = t - 6'd7;
      end
    end
    return t[WDAY_W-1:0];
  endfunction

endpackage

### sv/gdsd_req_if.sv
// gdsd_req_if: request channel of the date block, valid/ready plus payload
// depends on gdsd_pkg for field widths
interface gdsd_req_if #(
  parameter int OFFSET_BITS = gdsd_pkg::OFFSET_BITS_DEF
);
  import gdsd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [YEAR_W-1:0]         year;
  logic [MONTH_W-1:0]        month;
  logic [DAY_W-1:0]          day;
  logic signed [OFFSET_BITS-1:0] offset;
  logic [YEAR_W-1:0]         other_year;
  logic [MONTH_W-1:0]        other_month;
  logic [DAY_W-1:0]          other_day;

  modport source (output valid, req_type, year, month, day, offset,
                  other_year, other_month, other_day, input ready);
  modport sink   (input valid, req_type, year, month, day, offset,
                  other_year, other_month, other_day, output ready);
endinterface

### sv/gdsd_res_if.sv
// gdsd_res_if: result channel of the date block, valid/ready plus payload
// depends on gdsd_pkg for field widths
interface gdsd_res_if;
  import gdsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [YEAR_W-1:0]        out_year;
  logic [MONTH_W-1:0]       out_month;
  logic [DAY_W-1:0]         out_day;
  logic [WDAY_W-1:0]        weekday;
  logic signed [DIFF_W-1:0] day_difference;

  modport source (output valid, out_year, out_month, out_day, weekday, day_difference,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, weekday, day_difference,
                  output ready);
endinterface

### sv/gregorian_date_shift_and_diff.sv
// gregorian_date_shift_and_diff: shift a date by a signed day count, or take
// the day difference of two dates, with one shared accumulator adder
// depends on gdsd_pkg, gdsd_req_if, gdsd_res_if and assert_macros.svh
//
// usage:
//   in_ch carries one request: req_type 0 adds offset to year/month/day and
//   returns the normalized date and weekday (0 sunday), clamped to
//   0001-01-01 .. 9999-12-31; req_type 1 returns date minus other date in
//   days, clamped to +/-3660000. unused result fields are zero.
//   out_ch carries one result per request, valid/ready.
// operation:
//   the sums go through one accumulator adder under a sequencer. a date
//   serial is built from four year terms and a walk over the months. a
//   difference builds two serials and subtracts them. a shift builds the
//   serial, adds the offset, clamps, then walks 400-year cycles, years
//   inside the cycle (up to 399) and months; the year walk sets the worst case.
//   in_ch.ready is high only while the sequencer is idle; one request at a
//   time. the result sits in an output register, so a new request is taken
//   while the previous result waits; a second result waits for the first.
// reset: rst_n is synchronous, active low; clears the sequencer and out valid.
module gregorian_date_shift_and_diff #(
  parameter int OFFSET_BITS = gdsd_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gdsd_req_if.sink          in_ch,
  gdsd_res_if.source        out_ch
);
  import gdsd_pkg::*;

  localparam int ACC_W = ((OFFSET_BITS > SER_W) ? OFFSET_BITS : SER_W) + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_Y0    = 4'd1;
  localparam logic [3:0] S_Y1    = 4'd2;
  localparam logic [3:0] S_Y2    = 4'd3;
  localparam logic [3:0] S_Y3    = 4'd4;
  localparam logic [3:0] S_MS    = 4'd5;
  localparam logic [3:0] S_PASS  = 4'd6;
  localparam logic [3:0] S_DIFF  = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_CLAMP = 4'd10;
  localparam logic [3:0] S_CYC   = 4'd11;
  localparam logic [3:0] S_YR    = 4'd12;
  localparam logic [3:0] S_MW    = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  localparam logic signed [ACC_W-1:0] LIM_P  = ACC_W'(DIFF_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_N  = -ACC_W'(DIFF_LIMIT);
  localparam logic signed [ACC_W-1:0] LO_S   = ACC_W'(SER_LO);
  localparam logic signed [ACC_W-1:0] HI_S   = ACC_W'(SER_HI);

  // control
  logic [3:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] save_r, save_nxt;
  logic [BY_W-1:0]         by_r, by_nxt;
  logic [MONTH_W-1:0]      mo_r, mo_nxt;
  logic [DAY_W-1:0]        dy_r, dy_nxt;
  logic [MONTH_W-1:0]      mi_r, mi_nxt;
  logic                    leap_r, leap_nxt;
  logic [7:0]              q_r, q_nxt;
  logic                    type_r, type_nxt;
  logic                    pass_r, pass_nxt;
  logic signed [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [YEAR_W-1:0]       py_r, py_nxt;
  logic [MONTH_W-1:0]      pm_r, pm_nxt;
  logic [DAY_W-1:0]        pd_r, pd_nxt;
  logic [BY_W-1:0]         yb_r, yb_nxt;
  logic [8:0]              k_r, k_nxt;
  logic [6:0]              c100_r, c100_nxt;
  logic [WDAY_W-1:0]       w_r, w_nxt;

  logic [YEAR_W-1:0]        res_year_r, res_year_nxt;
  logic [MONTH_W-1:0]       res_month_r, res_month_nxt;
  logic [DAY_W-1:0]         res_day_r, res_day_nxt;
  logic [WDAY_W-1:0]        res_wday_r, res_wday_nxt;
  logic signed [DIFF_W-1:0] res_diff_r, res_diff_nxt;

  logic [YEAR_W-1:0]        oy_r, oy_nxt;
  logic [MONTH_W-1:0]       om_r, om_nxt;
  logic [DAY_W-1:0]         od_r, od_nxt;
  logic [WDAY_W-1:0]        ow_r, ow_nxt;
  logic signed [DIFF_W-1:0] odf_r, odf_nxt;

  // shared unit
  logic signed [ACC_W-1:0] alu_a, alu_b, alu_sum;
  logic                    alu_sub;

  // date loader
  logic [YEAR_W-1:0]  ld_year;
  logic [MONTH_W-1:0] ld_month;
  logic [DAY_W-1:0]   ld_day;
  logic [BY_W-1:0]    ld_by;
  logic [MONTH_W-1:0] ld_mo;

  logic               in_fire;
  logic               leapk;
  logic [DAY_W-1:0]   mlen;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // leap year of position k inside a 400-year cycle
  assign leapk = (k_r[1:0] == 2'd0) && ((c100_r != 7'd0) || (k_r == 9'd0));
  assign mlen  = month_len(leap_r, mi_r);

  // month zero is december of the year before, 13..15 roll into next year
  always_comb begin
    ld_by = BY_W'(ld_year) + BY_W'(YEAR_BIAS);
    ld_mo = ld_month;
    if (ld_month == 4'd0) begin
      ld_by = ld_by - BY_W'(1);
      ld_mo = 4'd12;
    end else if (ld_month > 4'd12) begin
      ld_by = ld_by + BY_W'(1);
      ld_mo = ld_month - 4'd12;
    end
  end

  // operand select for the accumulator adder
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_Y0: begin
        alu_a = '0;
        alu_b = ACC_W'(by_r) * ACC_W'(DAYS_YEAR);
      end
      S_Y1:  alu_b = ACC_W'((by_r + BY_W'(3)) >> 2);
      S_Y2: begin
        alu_b   = ACC_W'(q_r);
        alu_sub = 1'b1;
      end
      S_Y3:  alu_b = ACC_W'(q_r);
      S_MS: begin
        if (mi_r < mo_r) begin
          alu_b = ACC_W'(month_len(leap_r, mi_r));
        end else begin
          alu_b = ACC_W'(dy_r) - ACC_W'(1);
        end
      end
      S_DIFF: begin
        alu_b   = save_r;
        alu_sub = 1'b1;
      end
      S_ADD:  alu_b = ACC_W'(off_r);
      S_CYC: begin
        alu_b   = ACC_W'(CYCLE_DAYS);
        alu_sub = 1'b1;
      end
      S_YR: begin
        alu_b   = leapk ? ACC_W'(DAYS_YEAR + 1) : ACC_W'(DAYS_YEAR);
        alu_sub = 1'b1;
      end
      S_MW: begin
        alu_b   = ACC_W'(mlen);
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
    alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    acc_nxt   = acc_r;
    save_nxt  = save_r;
    by_nxt    = by_r;
    mo_nxt    = mo_r;
    dy_nxt    = dy_r;
    mi_nxt    = mi_r;
    leap_nxt  = leap_r;
    q_nxt     = q_r;
    type_nxt  = type_r;
    pass_nxt  = pass_r;
    off_nxt   = off_r;
    py_nxt    = py_r;
    pm_nxt    = pm_r;
    pd_nxt    = pd_r;
    yb_nxt    = yb_r;
    k_nxt     = k_r;
    c100_nxt  = c100_r;
    w_nxt     = w_r;
    res_year_nxt  = res_year_r;
    res_month_nxt = res_month_r;
    res_day_nxt   = res_day_r;
    res_wday_nxt  = res_wday_r;
    res_diff_nxt  = res_diff_r;
    oy_nxt  = oy_r;
    om_nxt  = om_r;
    od_nxt  = od_r;
    ow_nxt  = ow_r;
    odf_nxt = odf_r;
    ld_year  = py_r;
    ld_month = pm_r;
    ld_day   = pd_r;

    unique case (state_r)
      S_IDLE: begin
        // a difference request runs the other date first
        if (in_ch.req_type) begin
          ld_year  = in_ch.other_year;
          ld_month = in_ch.other_month;
          ld_day   = in_ch.other_day;
        end else begin
          ld_year  = in_ch.year;
          ld_month = in_ch.month;
          ld_day   = in_ch.day;
        end
        if (in_fire) begin
          type_nxt  = in_ch.req_type;
          off_nxt   = in_ch.offset;
          py_nxt    = in_ch.year;
          pm_nxt    = in_ch.month;
          pd_nxt    = in_ch.day;
          pass_nxt  = 1'b0;
          by_nxt    = ld_by;
          mo_nxt    = ld_mo;
          dy_nxt    = ld_day;
          state_nxt = S_Y0;
        end
      end
      S_Y0: begin
        acc_nxt   = alu_sum;
        q_nxt     = div100(by_r);
        state_nxt = S_Y1;
      end
      S_Y1: begin
        acc_nxt   = alu_sum;
        leap_nxt  = (by_r[1:0] == 2'd0) &&
                    ((by_r != BY_W'(q_r) * BY_W'(100)) || (q_r[1:0] == 2'd0));
        q_nxt     = div100(by_r + BY_W'(99));
        state_nxt = S_Y2;
      end
      S_Y2: begin
        acc_nxt   = alu_sum;
        q_nxt     = div100((by_r + BY_W'(399)) >> 2);
        state_nxt = S_Y3;
      end
      S_Y3: begin
        acc_nxt   = alu_sum;
        mi_nxt    = 4'd1;
        state_nxt = S_MS;
      end
      S_MS: begin
        acc_nxt = alu_sum;
        if (mi_r < mo_r) begin
          mi_nxt = mi_r + 4'd1;
        end else begin
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        if (type_r && !pass_r) begin
          save_nxt  = acc_r;
          pass_nxt  = 1'b1;
          by_nxt    = ld_by;
          mo_nxt    = ld_mo;
          dy_nxt    = ld_day;
          state_nxt = S_Y0;
        end else if (type_r) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_DIFF: begin
        acc_nxt   = alu_sum;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (acc_r > LIM_P) begin
          res_diff_nxt = DIFF_W'(LIM_P);
        end else if (acc_r < LIM_N) begin
          res_diff_nxt = DIFF_W'(LIM_N);
        end else begin
          res_diff_nxt = DIFF_W'(acc_r);
        end
        res_year_nxt  = '0;
        res_month_nxt = '0;
        res_day_nxt   = '0;
        res_wday_nxt  = '0;
        state_nxt     = S_OUT;
      end
      S_ADD: begin
        acc_nxt   = alu_sum;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        if (acc_r < LO_S) begin
          acc_nxt = LO_S;
        end else if (acc_r > HI_S) begin
          acc_nxt = HI_S;
        end
        yb_nxt    = '0;
        k_nxt     = '0;
        c100_nxt  = '0;
        w_nxt     = WDAY_W'(WDAY_SER0);
        state_nxt = S_CYC;
      end
      S_CYC: begin
        // 400-year cycles are a whole number of weeks
        if (!alu_sum[ACC_W-1]) begin
          acc_nxt = alu_sum;
          yb_nxt  = yb_r + BY_W'(YEAR_BIAS);
        end else begin
          state_nxt = S_YR;
        end
      end
      S_YR: begin
        if (!alu_sum[ACC_W-1]) begin
          acc_nxt  = alu_sum;
          yb_nxt   = yb_r + BY_W'(1);
          k_nxt    = k_r + 9'd1;
          c100_nxt = (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
          w_nxt    = mod7(6'(w_r) + (leapk ? 6'd2 : 6'd1));
        end else begin
          leap_nxt  = leapk;
          mi_nxt    = 4'd1;
          state_nxt = S_MW;
        end
      end
      S_MW: begin
        if (!alu_sum[ACC_W-1]) begin
          acc_nxt = alu_sum;
          mi_nxt  = mi_r + 4'd1;
          w_nxt   = mod7(6'(w_r) + 6'(mlen - 5'd28));
        end else begin
          res_year_nxt  = YEAR_W'(yb_r - BY_W'(YEAR_BIAS));
          res_month_nxt = mi_r;
          res_day_nxt   = DAY_W'(acc_r) + 5'd1;
          res_wday_nxt  = mod7(6'(w_r) + 6'(acc_r[DAY_W-1:0]));
          res_diff_nxt  = '0;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          oy_nxt        = res_year_r;
          om_nxt        = res_month_r;
          od_nxt        = res_day_r;
          ow_nxt        = res_wday_r;
          odf_nxt       = res_diff_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    save_r  <= save_nxt;
    by_r    <= by_nxt;
    mo_r    <= mo_nxt;
    dy_r    <= dy_nxt;
    mi_r    <= mi_nxt;
    leap_r  <= leap_nxt;
    q_r     <= q_nxt;
    type_r  <= type_nxt;
    pass_r  <= pass_nxt;
    off_r   <= off_nxt;
    py_r    <= py_nxt;
    pm_r    <= pm_nxt;
    pd_r    <= pd_nxt;
    yb_r    <= yb_nxt;
    k_r     <= k_nxt;
    c100_r  <= c100_nxt;
    w_r     <= w_nxt;
    res_year_r  <= res_year_nxt;
    res_month_r <= res_month_nxt;
    res_day_r   <= res_day_nxt;
    res_wday_r  <= res_wday_nxt;
    res_diff_r  <= res_diff_nxt;
    oy_r    <= oy_nxt;
    om_r    <= om_nxt;
    od_r    <= od_nxt;
    ow_r    <= ow_nxt;
    odf_r   <= odf_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_year       = oy_r;
  assign out_ch.out_month      = om_r;
  assign out_ch.out_day        = od_r;
  assign out_ch.weekday        = ow_r;
  assign out_ch.day_difference = odf_r;

  `include "assert_macros.svh"

  // the cycle walk leaves less than one 400-year cycle
  `ASSERT_IMPL(a_yr_range, state_r == S_YR, (acc_r >= 0) && (acc_r < ACC_W'(CYCLE_DAYS)), "year walk remainder out of range")
  // the month walk never runs past december
  `ASSERT_IMPL(a_mw_month, state_r == S_MW, (mi_r >= 4'd1) && (mi_r <= 4'd12) && (acc_r >= 0) && (acc_r < ACC_W'(DAYS_YEAR + 1)), "month walk out of range")
  // a finished result is only loaded when the output register is free
  `ASSERT_NEXT(a_out_load, (state_r == S_OUT) && out_valid_r && !out_ch.ready, state_r == S_OUT, "result overwrote a pending output")
  // weekday stays a valid day code
  `ASSERT_IMPL(a_wday, out_valid_r, out_ch.weekday != 3'd7, "weekday code out of range")

endmodule
